[src/idq_pkg.sv]
`timescale 1ns / 1ps

package idq_pkg;

  // default store depth and word width
  localparam int unsigned IDQ_DEPTH = 256;
  localparam int unsigned DATA_W    = 32;

  // operation codes carried by an input transfer
  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_REMOVE_ALL = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  // status codes carried by a result transfer
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

[src/integer_deque_with_search_top.sv]
`timescale 1ns / 1ps

// Deque of signed 32-bit words in a circular single-port-read memory of DEPTH
// entries, with search (first match, position counted from the front) and
// remove-all (order kept, returns the number removed). One operation is in
// flight at a time and every input transfer yields exactly one result
// transfer. Push, clear and refused or empty operations go from S_EXEC
// straight to S_FIN; pops pass through S_RDW as well, since the memory read
// port is registered. Search and remove-all read one stored entry per cycle
// through the memory read port in S_SCAN (search stops early at the first
// match). The store needs no clearing pass after reset; the block accepts an
// item in the first cycle after reset.
module integer_deque_with_search_top
  import idq_pkg::*;
#(
  parameter int unsigned DEPTH = IDQ_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_operation,
  input  logic signed [DATA_W-1:0]      in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_W-1:0]      out_result_value,
  output logic [1:0]                    out_status,
  output logic [$clog2(DEPTH+1)-1:0]    out_occupancy
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_RDW  = 5'b00100,
    S_SCAN = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  op_t                 op_r, op_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       kept_r, kept_nxt;
  logic [DATA_W-1:0]   res_r, res_nxt;
  status_t             st_r, st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_res_r, out_res_nxt;
  status_t             out_st_r, out_st_nxt;
  logic [CW-1:0]       out_occ_r, out_occ_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic                in_xfer;
  logic                full;
  logic                empty;
  logic                match;
  logic                last;
  logic [CW-1:0]       kept_upd;

  // physical slot of a position counted from the front
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(pos);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  idq_ram #(
    .DW    (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign match    = (ram_rdata == val_r);
  assign last     = (CW'(pos_r) == count_r - CW'(1));
  assign kept_upd = match ? kept_r : kept_r + CW'(1);

  // operation sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    kept_nxt      = kept_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_st_nxt    = out_st_r;
    out_occ_nxt   = out_occ_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = val_r;
    ram_raddr     = head_r;

    // result transfer frees the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = op_t'(in_operation);
          val_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt   = '0;
        st_nxt    = ST_OK;
        state_nxt = S_FIN;
        unique case (op_r)
          OP_PUSH_BACK: begin
            if (full) begin
              st_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = slot(head_r, count_r);
              count_nxt = count_r + CW'(1);
            end
          end
          OP_PUSH_FRONT: begin
            if (full) begin
              st_nxt = ST_FULL;
            end else begin
              head_nxt  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
              ram_we    = 1'b1;
              ram_waddr = head_nxt;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_POP_BACK: begin
            if (empty) begin
              st_nxt = ST_EMPTY;
            end else begin
              ram_raddr = slot(head_r, count_r - CW'(1));
              state_nxt = S_RDW;
            end
          end
          OP_POP_FRONT: begin
            if (empty) begin
              st_nxt = ST_EMPTY;
            end else begin
              ram_raddr = head_r;
              state_nxt = S_RDW;
            end
          end
          OP_SEARCH, OP_REMOVE_ALL: begin
            if (empty) begin
              st_nxt = ST_EMPTY;
            end else begin
              ram_raddr = head_r;
              pos_nxt   = '0;
              kept_nxt  = '0;
              state_nxt = S_SCAN;
            end
          end
          OP_CLEAR: begin
            head_nxt  = '0;
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end

      // pop data returns from the memory
      S_RDW: begin
        res_nxt   = ram_rdata;
        count_nxt = count_r - CW'(1);
        if (op_r == OP_POP_FRONT) begin
          head_nxt = slot(head_r, CW'(1));
        end
        state_nxt = S_FIN;
      end

      // one stored entry compared per cycle, next read issued alongside
      S_SCAN: begin
        if (op_r == OP_SEARCH) begin
          if (match) begin
            res_nxt   = DATA_W'(pos_r);
            st_nxt    = ST_OK;
            state_nxt = S_FIN;
          end else if (last) begin
            st_nxt    = ST_NOT_FOUND;
            state_nxt = S_FIN;
          end
        end else begin
          if (!match) begin
            ram_we    = 1'b1;
            ram_waddr = slot(head_r, kept_r);
            ram_wdata = ram_rdata;
          end
          kept_nxt = kept_upd;
          if (last) begin
            res_nxt   = DATA_W'(count_r - kept_upd);
            count_nxt = kept_upd;
            state_nxt = S_FIN;
          end
        end
        if (state_nxt == S_SCAN) begin
          ram_raddr = slot(head_r, CW'(pos_r) + CW'(1));
          pos_nxt   = pos_r + AW'(1);
        end
      end

      // hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_st_nxt    = st_r;
          out_occ_nxt   = count_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    pos_r     <= pos_nxt;
    kept_r    <= kept_nxt;
    res_r     <= res_nxt;
    st_r      <= st_nxt;
    out_res_r <= out_res_nxt;
    out_st_r  <= out_st_nxt;
    out_occ_r <= out_occ_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_st_r;
  assign out_occupancy    = out_occ_r;

  // occupancy never exceeds the store
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // head pointer stays inside the store
  assert property (@(posedge clk) disable iff (!rst_n)
    CW'(head_r) < CW'(DEPTH))
    else $error("head pointer out of range");

  // a scan only looks at stored positions
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(pos_r) < count_r))
    else $error("scan position past last entry");

  // compaction never runs ahead of the read side
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (kept_r <= CW'(pos_r)))
    else $error("compaction write ahead of scan");

  // an input transfer always starts execution next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_EXEC))
    else $error("accepted item not executed");

endmodule

[src/idq_ram.sv]
`timescale 1ns / 1ps

module idq_ram #(
  parameter int unsigned DW    = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import idq_pkg::*;

  localparam int unsigned OCC_W       = $clog2(IDQ_DEPTH + 1);
  localparam logic [2:0]  OP_UNUSED   = 3'd7;
  localparam int unsigned TARGET_OPS  = 1650;
  localparam int unsigned TAIL_CYCLES = IDQ_DEPTH + 40;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  // idling behavior attached to each queued operation
  typedef enum int unsigned {
    MODE_FREE,
    MODE_SRC_IDLE,
    MODE_SNK_STALL,
    MODE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] value;
    idle_mode_t               mode;
    bit                       drain;
  } deque_op_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
  } deque_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               in_operation = OP_CLEAR;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_result_value;
  logic [1:0]               out_status;
  logic [OCC_W-1:0]         out_occupancy;

  deque_op_t                queued_ops[$];
  deque_result_t            predicted_results[$];
  logic signed [DATA_W-1:0] shadow_words[$];
  idle_mode_t               idle_mode = MODE_FREE;

  int unsigned mismatches = 0;
  int unsigned ops_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned full_refusals = 0;
  int unsigned empty_hits = 0;
  int unsigned key_misses = 0;
  int unsigned peak_occupancy = 0;
  int unsigned cycles = 0;

  integer_deque_with_search_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // apply one operation to the shadow deque and return what the block should answer
  function automatic deque_result_t apply_op(logic [2:0] op, logic signed [DATA_W-1:0] key);
    deque_result_t            r;
    logic signed [DATA_W-1:0] kept[$];
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (shadow_words.size() >= IDQ_DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_BACK) begin
          shadow_words.push_back(key);
        end else begin
          shadow_words.push_front(key);
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (shadow_words.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_POP_BACK) begin
          r.value = shadow_words.pop_back();
        end else begin
          r.value = shadow_words.pop_front();
        end
      end
      OP_SEARCH: begin
        if (shadow_words.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOT_FOUND;
          // first match from the front, last entry included
          for (int i = 0; i < shadow_words.size(); i++) begin
            if (r.status == ST_NOT_FOUND && shadow_words[i] == key) begin
              r.value  = i;
              r.status = ST_OK;
            end
          end
        end
      end
      OP_REMOVE_ALL: begin
        if (shadow_words.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // compact while keeping order
          foreach (shadow_words[i]) begin
            if (shadow_words[i] != key) kept.push_back(shadow_words[i]);
          end
          r.value      = shadow_words.size() - kept.size();
          shadow_words = kept;
        end
      end
      OP_CLEAR: begin
        shadow_words.delete();
      end
      default: begin
      end
    endcase
    r.occupancy = OCC_W'(shadow_words.size());
    return r;
  endfunction

  // input side: present queued operations, predict on each transfer
  always @(posedge clk) begin : driver
    deque_op_t     nxt;
    deque_result_t want;
    logic          holding;
    bit            go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      holding = in_valid;
      if (in_valid && !in_stall) begin
        want = apply_op(in_operation, in_value);
        predicted_results.push_back(want);
        ops_accepted++;
        if (want.status == ST_FULL) full_refusals++;
        if (want.status == ST_EMPTY) empty_hits++;
        if (want.status == ST_NOT_FOUND) key_misses++;
        if (want.occupancy > peak_occupancy) peak_occupancy = 32'(want.occupancy);
        holding = 1'b0;
      end
      if (!holding) begin
        go = queued_ops.size() != 0;
        if (go) begin
          case (queued_ops[0].mode)
            MODE_SRC_IDLE: go = $urandom_range(0, 99) >= 68;
            MODE_BOTH:     go = $urandom_range(0, 99) >= 29;
            default:       go = 1'b1;
          endcase
          // hold off until the block has answered everything
          if (queued_ops[0].drain && predicted_results.size() != 0) go = 1'b0;
        end
        if (go) begin
          nxt = queued_ops.pop_front();
          in_valid     <= 1'b1;
          in_operation <= nxt.op;
          in_value     <= nxt.value;
          idle_mode    <= nxt.mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: random stall, compare each transfer with the oldest prediction
  always @(posedge clk) begin : monitor
    deque_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          if (mismatches < 10) $display("tb: result with nothing expected: value %0d status %0d occ %0d",
                                        out_result_value, out_status, out_occupancy);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_result_value !== want.value || out_status !== want.status ||
              out_occupancy !== want.occupancy) begin
            if (mismatches < 10) begin
              $display("tb: result %0d mismatch: value %0d/%0d status %0d/%0d occ %0d/%0d (exp/got)",
                       results_seen, want.value, out_result_value, want.status, out_status,
                       want.occupancy, out_occupancy);
            end
            mismatches++;
          end
        end
      end
      case (idle_mode)
        MODE_SNK_STALL: out_stall <= $urandom_range(0, 99) < 68;
        MODE_BOTH:      out_stall <= $urandom_range(0, 99) < 29;
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic add_op(logic [2:0] op, logic signed [DATA_W-1:0] value, idle_mode_t mode,
                        bit drain = 1'b0);
    deque_op_t t;
    t.op    = op;
    t.value = value;
    t.mode  = mode;
    t.drain = drain;
    queued_ops.push_back(t);
  endtask

  // half the time keys from a small set so that duplicates, hits and removals happen
  function automatic logic signed [DATA_W-1:0] pick_word();
    if ($urandom_range(0, 7) > 3) return $urandom;
    case ($urandom_range(0, 5))
      0:       return 32'sh0000_0000;
      1:       return -32'sd1;
      2:       return 32'sh8000_0000;
      3:       return 32'sh7fff_ffff;
      4:       return 32'sd7;
      default: return 32'sd42;
    endcase
  endfunction

  // fill to capacity with refused pushes, scan the full store, then drain partly
  task automatic fill_run(idle_mode_t mode);
    add_op(OP_CLEAR, $urandom, mode, 1'b1);
    repeat (IDQ_DEPTH + 3) begin
      add_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word(), mode);
    end
    repeat (3) add_op(OP_SEARCH, pick_word(), mode);
    add_op(OP_SEARCH, $urandom, mode);
    add_op(OP_REMOVE_ALL, pick_word(), mode);
    repeat (4) add_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word(), mode);
    repeat (30) add_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom, mode);
    repeat (3) add_op(OP_REMOVE_ALL, pick_word(), mode);
    add_op(OP_SEARCH, pick_word(), mode);
    add_op(OP_CLEAR, $urandom, mode);
  endtask

  // weighted mix with pushes ahead of pops so the deque grows between clears
  task automatic mixed_run(idle_mode_t mode, int unsigned n);
    int unsigned r;
    logic [2:0]  op;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 22) op = OP_PUSH_BACK;
      else if (r < 40) op = OP_PUSH_FRONT;
      else if (r < 52) op = OP_POP_BACK;
      else if (r < 62) op = OP_POP_FRONT;
      else if (r < 78) op = OP_SEARCH;
      else if (r < 90) op = OP_REMOVE_ALL;
      else if (r < 96) op = OP_CLEAR;
      else op = OP_UNUSED;
      add_op(op, pick_word(), mode, k == 0);
    end
  endtask

  initial begin
    int unsigned seg;
    // directed: empty cases, extremes, search at both ends, removals, clear
    add_op(OP_POP_BACK,   32'sd0,           MODE_FREE, 1'b1);
    add_op(OP_POP_FRONT,  32'sd0,           MODE_FREE);
    add_op(OP_SEARCH,     32'sd0,           MODE_FREE);
    add_op(OP_REMOVE_ALL, 32'sd0,           MODE_FREE);
    add_op(OP_UNUSED,     32'sh1234_5678,   MODE_FREE);
    add_op(OP_PUSH_BACK,  32'sh7fff_ffff,   MODE_FREE);
    add_op(OP_PUSH_FRONT, 32'sh8000_0000,   MODE_FREE);
    add_op(OP_PUSH_BACK,  -32'sd1,          MODE_FREE);
    add_op(OP_PUSH_BACK,  32'sd0,           MODE_FREE);
    add_op(OP_PUSH_FRONT, 32'sd1,           MODE_FREE);
    add_op(OP_UNUSED,     -32'sd1,          MODE_FREE);
    add_op(OP_SEARCH,     32'sh8000_0000,   MODE_FREE);
    add_op(OP_SEARCH,     32'sd0,           MODE_FREE);
    add_op(OP_SEARCH,     32'sd5,           MODE_FREE);
    add_op(OP_REMOVE_ALL, 32'sd12345,       MODE_FREE);
    add_op(OP_PUSH_BACK,  -32'sd1,          MODE_FREE);
    add_op(OP_REMOVE_ALL, -32'sd1,          MODE_FREE);
    add_op(OP_POP_BACK,   32'sd0,           MODE_FREE);
    add_op(OP_POP_FRONT,  32'sd0,           MODE_FREE);
    add_op(OP_CLEAR,      32'sd0,           MODE_FREE);
    add_op(OP_POP_FRONT,  32'sd0,           MODE_FREE);
    add_op(OP_PUSH_BACK,  32'sh5555_5555,   MODE_FREE);
    add_op(OP_PUSH_FRONT, 32'shaaaa_aaaa,   MODE_FREE);
    add_op(OP_SEARCH,     32'shaaaa_aaaa,   MODE_FREE);
    add_op(OP_CLEAR,      32'sd0,           MODE_FREE);

    // random: mixed segments cycling the idle modes, two full-store runs
    mixed_run(MODE_SRC_IDLE, 120);
    mixed_run(MODE_SNK_STALL, 120);
    fill_run(MODE_FREE);
    mixed_run(MODE_BOTH, 120);
    mixed_run(MODE_FREE, 120);
    fill_run(MODE_BOTH);
    seg = 1;
    while (queued_ops.size() < TARGET_OPS) begin
      mixed_run(idle_mode_t'(seg % 4), 120);
      seg++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (queued_ops.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (predicted_results.size() != 0) begin
      $display("tb: %0d results never arrived", predicted_results.size());
      mismatches++;
    end
    $display("tb: %0d operations, %0d results checked, %0d mismatches, peak occupancy %0d",
             ops_accepted, results_seen, mismatches, peak_occupancy);
    $display("tb: %0d refused pushes, %0d empty-store cases, %0d missed searches",
             full_refusals, empty_hits, key_misses);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[integer_deque_with_search_top.f]
src/idq_pkg.sv
src/idq_ram.sv
src/integer_deque_with_search_top.sv
verif/tb.sv
